FILE: hw/rtl/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
package sfr_pkg;

	localparam int PLEN_W = 7;

	localparam logic [7:0] HDR_FIRST    = 8'h55;
	localparam logic [7:0] HDR_SECOND   = 8'h00;
	localparam logic [7:0] TRL_FIRST    = 8'h00;
	localparam logic [7:0] TRL_SECOND   = 8'hAA;
	localparam logic [7:0] MIN_LEN      = 8'd9;
	localparam logic [7:0] LEN_OVERHEAD = 8'd8;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'd0,
		PH_HDR2   = 4'd1,
		PH_LEN    = 4'd2,
		PH_TYPE   = 4'd3,
		PH_ADDR   = 4'd4,
		PH_DATA   = 4'd5,
		PH_CHECK  = 4'd6,
		PH_TRAIL1 = 4'd7,
		PH_TRAIL2 = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_TRAILER  = 2'd2,
		ST_LENGTH   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		EM_IDLE = 2'd0,
		EM_READ = 2'd1,
		EM_LOAD = 2'd2,
		EM_SHOW = 2'd3
	} emit_t;

	typedef struct packed {
		status_t             status;
		logic [7:0]          ftype;
		logic [7:0]          faddr;
		logic [PLEN_W-1:0]   plen;
	} job_t;

endpackage

FILE: hw/rtl/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/sfr_front.sv
// Frame parser: hunts the header, checks length, checksum and trailer, stores payload.
module sfr_front #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  byte_valid,
	output logic                                                  byte_stall,
	input  logic [7:0]                                            rx_byte,
	output logic                                                  wr_en,
	output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] wr_addr,
	output logic [7:0]                                            wr_data,
	output logic                                                  push,
	output sfr_pkg::job_t                                         push_job,
	input  logic                                                  q_full,
	input  logic                                                  good_done
);

	import sfr_pkg::*;

	localparam int AddrW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LenMax = MAX_PAYLOAD + 8;

	phase_t     phase_q, phase_d;
	logic [7:0] len_q, len_d;
	logic [7:0] type_q, type_d;
	logic [7:0] addr_q, addr_d;
	logic [5:0] cnt_q, cnt_d;
	logic [7:0] sum_q, sum_d;
	logic       good_q;
	logic       acc;
	logic [7:0] plen;
	logic [5:0] cnt_inc;

	assign plen    = (len_q >= LEN_OVERHEAD) ? (len_q - LEN_OVERHEAD) : 8'd0;
	assign cnt_inc = cnt_q + 6'd1;

	assign byte_stall = ((phase_q == PH_DATA) && good_q) ||
		(q_full && (phase_q inside {PH_LEN, PH_CHECK, PH_TRAIL1, PH_TRAIL2}));
	assign acc = byte_valid && !byte_stall;

	assign wr_addr = cnt_q[AddrW-1:0];
	assign wr_data = rx_byte;

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		type_d   = type_q;
		addr_d   = addr_q;
		cnt_d    = cnt_q;
		sum_d    = sum_q;
		push     = 1'b0;
		push_job = '0;
		wr_en    = 1'b0;
		if (acc) begin
			case (phase_q)
				PH_HDR2: begin
					phase_d = (rx_byte == HDR_SECOND) ? PH_LEN : PH_HUNT;
				end
				PH_LEN: begin
					len_d = rx_byte;
					if ((rx_byte < MIN_LEN) || ({1'b0, rx_byte} > 9'(LenMax))) begin
						push            = 1'b1;
						push_job.status = ST_LENGTH;
					end else begin
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					type_d  = rx_byte;
					phase_d = PH_ADDR;
				end
				PH_ADDR: begin
					addr_d  = rx_byte;
					cnt_d   = 6'd0;
					sum_d   = len_q + type_q + rx_byte;
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					wr_en = ({1'b0, cnt_q} < 7'(MAX_PAYLOAD));
					sum_d = sum_q + rx_byte;
					cnt_d = cnt_inc;
					if ({2'b00, cnt_inc} >= plen) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (rx_byte != ~sum_q) begin
						push            = 1'b1;
						push_job.status = ST_CHECKSUM;
					end else begin
						phase_d = PH_TRAIL1;
					end
				end
				PH_TRAIL1: begin
					if (rx_byte != TRL_FIRST) begin
						push            = 1'b1;
						push_job.status = ST_TRAILER;
					end else begin
						phase_d = PH_TRAIL2;
					end
				end
				PH_TRAIL2: begin
					push = 1'b1;
					if (rx_byte != TRL_SECOND) begin
						push_job.status = ST_TRAILER;
					end else begin
						push_job.status = ST_GOOD;
						push_job.ftype  = type_q;
						push_job.faddr  = addr_q;
						push_job.plen   = plen[PLEN_W-1:0];
						phase_d         = PH_HUNT;
					end
				end
				default: begin
					phase_d = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
				end
			endcase
			// drop the frame on any fault
			if (push && (push_job.status != ST_GOOD)) begin
				phase_d = PH_HUNT;
				len_d   = 8'd0;
				addr_d  = 8'd0;
				cnt_d   = 6'd0;
				sum_d   = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= 8'd0;
			type_q <= 8'd0;
			addr_q <= 8'd0;
			cnt_q  <= 6'd0;
			sum_q  <= 8'd0;
			good_q <= 1'b0;
		end else begin
			len_q  <= len_d;
			type_q <= type_d;
			addr_q <= addr_d;
			cnt_q  <= cnt_d;
			sum_q  <= sum_d;
			if (push && (push_job.status == ST_GOOD)) begin
				good_q <= 1'b1;
			end else if (good_done) begin
				good_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !good_q)
		else $error("payload store written while a good frame is still pending");
`endif

endmodule

FILE: hw/rtl/sfr_queue.sv
// Two-entry job queue between the parser and the result emitter.
module sfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfr_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output sfr_pkg::job_t head
);

	import sfr_pkg::*;

	localparam int Depth = 2;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full      = (cnt_q == CntW'(Depth));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("job popped from an empty queue");
`endif

endmodule

FILE: hw/rtl/sfr_back.sv
// Result emitter: turns queued jobs into status beats or payload runs.
module sfr_back #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  q_valid,
	input  sfr_pkg::job_t                                         q_job,
	output logic                                                  q_pop,
	output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] rd_addr,
	input  logic [7:0]                                            rd_data,
	output logic                                                  good_done,
	output logic                                                  res_valid,
	input  logic                                                  res_stall,
	output logic [1:0]                                            status,
	output logic [7:0]                                            frame_type,
	output logic [7:0]                                            frame_addr,
	output logic [5:0]                                            payload_len,
	output logic [4:0]                                            byte_index,
	output logic [7:0]                                            payload_byte,
	output logic                                                  last
);

	import sfr_pkg::*;

	localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	emit_t             state_q, state_d;
	logic [PLEN_W-1:0] k_q;
	job_t              job_q;
	logic              valid_q;
	status_t           status_q;
	logic [7:0]        type_q;
	logic [7:0]        addr_q;
	logic [5:0]        plen_q;
	logic [4:0]        idx_q;
	logic [7:0]        data_q;
	logic              last_q;
	logic              load_err;
	logic              load_good;
	logic              take;
	logic              k_adv;

	assign rd_addr = k_q[AddrW-1:0];

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		good_done = 1'b0;
		load_err  = 1'b0;
		load_good = 1'b0;
		take      = 1'b0;
		k_adv     = 1'b0;
		case (state_q)
			EM_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_job.status != ST_GOOD) begin
						load_err = 1'b1;
						state_d  = EM_SHOW;
					end else begin
						state_d = EM_READ;
					end
				end
			end
			EM_READ: begin
				state_d = EM_LOAD;
			end
			EM_LOAD: begin
				load_good = 1'b1;
				state_d   = EM_SHOW;
			end
			EM_SHOW: begin
				if (!res_stall) begin
					take = 1'b1;
					if (last_q) begin
						good_done = (status_q == ST_GOOD);
						state_d   = EM_IDLE;
					end else begin
						k_adv   = 1'b1;
						state_d = EM_READ;
					end
				end
			end
			default: begin
				state_d = EM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (load_err || load_good) begin
				valid_q <= 1'b1;
			end else if (take) begin
				valid_q <= 1'b0;
			end
			if (q_pop) begin
				k_q <= '0;
			end else if (k_adv) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (load_err) begin
			status_q <= q_job.status;
			type_q   <= 8'd0;
			addr_q   <= 8'd0;
			plen_q   <= 6'd0;
			idx_q    <= 5'd0;
			data_q   <= 8'd0;
			last_q   <= 1'b1;
		end else if (load_good) begin
			status_q <= ST_GOOD;
			type_q   <= job_q.ftype;
			addr_q   <= job_q.faddr;
			plen_q   <= job_q.plen[5:0];
			idx_q    <= k_q[4:0];
			data_q   <= rd_data;
			last_q   <= (PLEN_W'(k_q + 1'b1) == job_q.plen);
		end
	end

	assign res_valid    = valid_q;
	assign status       = status_q;
	assign frame_type   = type_q;
	assign frame_addr   = addr_q;
	assign payload_len  = plen_q;
	assign byte_index   = idx_q;
	assign payload_byte = data_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_fault_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (status_q != ST_GOOD)) |-> (last_q && (plen_q == 6'd0) && (data_q == 8'd0)))
		else $error("status beat is not a single zeroed beat");
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (status_q == ST_GOOD) && last_q) |-> (idx_q == 5'(plen_q - 6'd1)))
		else $error("payload run ends at the wrong index");
`endif

endmodule

FILE: hw/rtl/serial_frame_receiver.sv
// Top level of the serial frame receiver.
// Takes one received serial byte per beat and parses frames of the form 0x55 0x00, length,
// type, address, length-8 payload bytes, checksum, 0x00 0xAA. The parser takes a byte every
// cycle; it holds off a payload byte only while the previous good frame is still queued or
// being sent out, and a length, checksum or trailer byte only while its two-entry job queue
// is full. A good frame comes out as a run of one beat per payload byte, each beat passing
// through payload store read, output load and presentation, plus any output stall; a fault
// gives a single status beat once its job has passed the queue and the output registers,
// and hunting for the next header resumes at once.
module serial_frame_receiver #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] status,
	output logic [7:0] frame_type,
	output logic [7:0] frame_addr,
	output logic [5:0] payload_len,
	output logic [4:0] byte_index,
	output logic [7:0] payload_byte,
	output logic       last
);

	import sfr_pkg::*;

	localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic             wr_en;
	logic [AddrW-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic [AddrW-1:0] rd_addr;
	logic [7:0]       rd_data;
	logic             push;
	job_t             push_job;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	job_t             q_head;
	logic             good_done;

	sfr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.rx_byte    (rx_byte),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full),
		.good_done  (good_done)
	);

	sfr_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	sfr_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_job        (q_head),
		.q_pop        (q_pop),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.good_done    (good_done),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.frame_type   (frame_type),
		.frame_addr   (frame_addr),
		.payload_len  (payload_len),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.last         (last)
	);

endmodule

FILE: dv/tb_serial_frame_receiver.sv
// Self-checking testbench for serial_frame_receiver: directed rows, then random frames.
`timescale 1ns / 100ps

module tb_serial_frame_receiver;
	import sfr_pkg::*;

	localparam int MAX_PAYLOAD    = 32;
	localparam int RANDOM_ITEMS   = 156;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		status_t    st;
		logic [7:0] ftype;
		logic [7:0] faddr;
		logic [5:0] plen;
		logic [4:0] idx;
		logic [7:0] data;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic [7:0] b;
		logic       fixed;
		status_t    want;
	} row_t;

	typedef enum {
		FL_NONE, FL_CHECKSUM, FL_TRAIL1, FL_TRAIL2, FL_LENGTH, FL_HEADER, FL_NOISE
	} flaw_t;

	localparam row_t DIRECTED_ROWS [24] = '{
		'{8'h55, 1'b0, ST_GOOD}, '{8'h00, 1'b0, ST_GOOD}, '{8'h08, 1'b1, ST_LENGTH},
		'{8'h55, 1'b0, ST_GOOD}, '{8'h01, 1'b0, ST_GOOD},
		'{8'h55, 1'b0, ST_GOOD}, '{8'h00, 1'b0, ST_GOOD}, '{8'h29, 1'b1, ST_LENGTH},
		'{8'h55, 1'b0, ST_GOOD}, '{8'h00, 1'b0, ST_GOOD}, '{8'h09, 1'b0, ST_GOOD},
		'{8'hFF, 1'b0, ST_GOOD}, '{8'h00, 1'b0, ST_GOOD}, '{8'hFF, 1'b0, ST_GOOD},
		'{8'hF8, 1'b0, ST_GOOD}, '{8'h00, 1'b0, ST_GOOD}, '{8'hAA, 1'b0, ST_GOOD},
		'{8'h55, 1'b0, ST_GOOD}, '{8'h00, 1'b0, ST_GOOD}, '{8'h09, 1'b0, ST_GOOD},
		'{8'h00, 1'b0, ST_GOOD}, '{8'hFF, 1'b0, ST_GOOD}, '{8'h00, 1'b0, ST_GOOD},
		'{8'h00, 1'b1, ST_CHECKSUM}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [1:0] status;
	logic [7:0] frame_type;
	logic [7:0] frame_addr;
	logic [5:0] payload_len;
	logic [4:0] byte_index;
	logic [7:0] payload_byte;
	logic       last;

	beat_t      pending_beats [$];
	int         fails = 0;
	int         beats_taken = 0;
	int         frame_bytes = 0;
	int         burst_left = 0;

	phase_t     prs_phase;
	logic [7:0] prs_len;
	logic [7:0] prs_type;
	logic [7:0] prs_addr;
	logic [5:0] prs_count;
	logic [7:0] prs_sum;
	logic [7:0] prs_store [MAX_PAYLOAD];

	serial_frame_receiver #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.frame_type(frame_type),
		.frame_addr(frame_addr),
		.payload_len(payload_len),
		.byte_index(byte_index),
		.payload_byte(payload_byte),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic beat_t fault_beat(status_t st);
		beat_t r;
		r = '0;
		r.st = st;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic clear_parser();
		prs_phase = PH_HUNT;
		prs_len = '0;
		prs_type = '0;
		prs_addr = '0;
		prs_count = '0;
		prs_sum = '0;
		foreach (prs_store[i]) prs_store[i] = '0;
	endtask

	task automatic parser_fault(status_t st);
		pending_beats.push_back(fault_beat(st));
		prs_phase = PH_HUNT;
		prs_len = '0;
		prs_addr = '0;
		prs_count = '0;
		prs_sum = '0;
	endtask

	task automatic advance_parser(input logic [7:0] b);
		int plen;
		beat_t r;
		plen = (prs_len >= LEN_OVERHEAD) ? int'(prs_len) - int'(LEN_OVERHEAD) : 0;
		case (prs_phase)
			PH_HDR2: prs_phase = (b == HDR_SECOND) ? PH_LEN : PH_HUNT;
			PH_LEN: begin
				prs_len = b;
				if (b < MIN_LEN || int'(b) - int'(LEN_OVERHEAD) > MAX_PAYLOAD)
					parser_fault(ST_LENGTH);
				else
					prs_phase = PH_TYPE;
			end
			PH_TYPE: begin
				prs_type = b;
				prs_phase = PH_ADDR;
			end
			PH_ADDR: begin
				prs_addr = b;
				prs_count = '0;
				prs_sum = prs_len + prs_type + b;
				prs_phase = PH_DATA;
			end
			PH_DATA: begin
				if (prs_count < MAX_PAYLOAD)
					prs_store[prs_count] = b;
				prs_sum = prs_sum + b;
				prs_count = prs_count + 6'd1;
				if (prs_count >= plen)
					prs_phase = PH_CHECK;
			end
			PH_CHECK: begin
				if (b != ~prs_sum)
					parser_fault(ST_CHECKSUM);
				else
					prs_phase = PH_TRAIL1;
			end
			PH_TRAIL1: begin
				if (b != TRL_FIRST)
					parser_fault(ST_TRAILER);
				else
					prs_phase = PH_TRAIL2;
			end
			PH_TRAIL2: begin
				if (b != TRL_SECOND) begin
					parser_fault(ST_TRAILER);
				end else begin
					prs_phase = PH_HUNT;
					if (plen > MAX_PAYLOAD)
						plen = MAX_PAYLOAD;
					for (int k = 0; k < plen; k++) begin
						r.st = ST_GOOD;
						r.ftype = prs_type;
						r.faddr = prs_addr;
						r.plen = 6'(plen);
						r.idx = 5'(k);
						r.data = prs_store[k];
						r.last = (k + 1 == plen);
						pending_beats.push_back(r);
					end
				end
			end
			default: prs_phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
		endcase
	endtask

	task automatic offer_byte(input logic [7:0] b, input logic fixed, input status_t want);
		int gap;
		int depth;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				byte_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		byte_valid <= 1'b1;
		rx_byte <= b;
		// hold the beat until taken
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		depth = pending_beats.size();
		advance_parser(b);
		if (fixed) begin
			// drop the parser's view and keep the typed fault
			while (pending_beats.size() > depth) void'(pending_beats.pop_back());
			pending_beats.push_back(fault_beat(want));
		end
	endtask

	task automatic send_frame(input int plen, input flaw_t flaw);
		logic [7:0] seq [$];
		logic [7:0] lenb;
		logic [7:0] ftype;
		logic [7:0] faddr;
		logic [7:0] sum;
		logic [7:0] pick;
		int n;
		case (flaw)
			FL_NOISE: begin
				n = $urandom_range(1, 6);
				repeat (n) seq.push_back(8'($urandom));
			end
			FL_HEADER: seq = '{HDR_FIRST, 8'($urandom_range(1, 255))};
			FL_LENGTH: begin
				if ($urandom_range(0, 1))
					lenb = 8'($urandom_range(0, int'(MIN_LEN) - 1));
				else
					lenb = 8'($urandom_range(MAX_PAYLOAD + int'(MIN_LEN), 255));
				seq = '{HDR_FIRST, HDR_SECOND, lenb};
			end
			default: begin
				lenb = 8'(plen) + LEN_OVERHEAD;
				ftype = 8'($urandom);
				faddr = 8'($urandom);
				sum = lenb + ftype + faddr;
				seq = '{HDR_FIRST, HDR_SECOND, lenb, ftype, faddr};
				repeat (plen) begin
					pick = 8'($urandom);
					sum = sum + pick;
					seq.push_back(pick);
				end
				pick = ~sum;
				if (flaw == FL_CHECKSUM)
					pick = pick ^ 8'($urandom_range(1, 255));
				seq.push_back(pick);
				seq.push_back((flaw == FL_TRAIL1) ? 8'($urandom_range(1, 255)) : TRL_FIRST);
				pick = TRL_SECOND;
				if (flaw == FL_TRAIL2)
					do pick = 8'($urandom); while (pick == TRL_SECOND);
				seq.push_back(pick);
			end
		endcase
		foreach (seq[i]) offer_byte(seq[i], 1'b0, ST_GOOD);
		frame_bytes += seq.size();
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && res_valid === 1'b1 && !res_stall) begin
			beats_taken++;
			if (pending_beats.size() == 0) begin
				$error("result beat with nothing expected");
				fails++;
			end else begin
				want = pending_beats.pop_front();
				check_field("status", 8'(want.st), 8'(status));
				check_field("frame_type", want.ftype, frame_type);
				check_field("frame_addr", want.faddr, frame_addr);
				check_field("payload_len", 8'(want.plen), 8'(payload_len));
				check_field("byte_index", 8'(want.idx), 8'(byte_index));
				check_field("payload_byte", want.data, payload_byte);
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	initial begin
		int stall_pct;
		int stretch;
		bit held;
		held = 1'b0;
		forever begin
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1)) ? 25 : 75);
			stretch = $urandom_range(8, 60);
			repeat (stretch) begin
				@(negedge clk);
				res_stall <= ($urandom_range(0, 99) < stall_pct);
			end
			if (!held && beats_taken >= 20) begin
				held = 1'b1;
				@(negedge clk);
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((byte_valid && byte_stall === 1'b0) || (res_valid === 1'b1 && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("serial_frame_receiver regression: fail");
		$finish;
	end

	initial begin
		int frame_no;
		int roll;
		int plen;
		flaw_t flaw;
		clear_parser();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[i])
			offer_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

		frame_no = 0;
		while (frame_bytes < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 60)
				flaw = FL_NONE;
			else if (roll < 68)
				flaw = FL_CHECKSUM;
			else if (roll < 74)
				flaw = FL_TRAIL1;
			else if (roll < 80)
				flaw = FL_TRAIL2;
			else if (roll < 88)
				flaw = FL_LENGTH;
			else if (roll < 94)
				flaw = FL_HEADER;
			else
				flaw = FL_NOISE;
			if ($urandom_range(0, 7) == 0)
				plen = $urandom_range(7, MAX_PAYLOAD);
			else
				plen = $urandom_range(1, 6);
			if (frame_no == 1) begin
				plen = MAX_PAYLOAD;
				flaw = FL_NONE;
			end
			send_frame(plen, flaw);
			frame_no++;
		end
		@(negedge clk);
		byte_valid <= 1'b0;

		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_beats.size() != 0) begin
			$error("%0d result beats never arrived", pending_beats.size());
			fails++;
		end

		if (fails == 0)
			$display("serial_frame_receiver regression: pass");
		else
			$display("serial_frame_receiver regression: fail");
		$finish;
	end

endmodule
